// File: rtl/stu_pkg.sv
package stu_pkg;

    localparam int TOKEN_MAX_DEF = 64;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Scanner modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_SLASH   = 5'b00010,
        MODE_COMMENT = 5'b00100,
        MODE_WORD    = 5'b01000,
        MODE_QUOTED  = 5'b10000
    } t_mode;

    // Emitter phases, one-hot
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_CHARS = 4'b0010,
        PH_EMPTY = 4'b0100,
        PH_END   = 4'b1000
    } t_phase;

    // Request from scanner to emitter
    typedef struct packed {
        logic start;     // token or marker finished on this beat
        logic end_only;  // only an end-of-data marker
        logic empty;     // token has no characters
        logic then_end;  // follow the token with an end-of-data marker
    } t_emit_req;

    // 7-bit ASCII above space (33..127)
    function automatic logic is_word_byte(input logic [7:0] b);
        return (b > CH_SPACE) && !b[7];
    endfunction

endpackage

// File: rtl/stu_ram.sv
module stu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/stu_scan.sv
module stu_scan #(
    parameter int TOKEN_MAX = stu_pkg::TOKEN_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [7:0]                   i_in_byte,
    input  logic                         i_busy,
    output logic                         o_we,
    output logic [$clog2(TOKEN_MAX)-1:0] o_waddr,
    output logic [7:0]                   o_wdata,
    output stu_pkg::t_emit_req           o_req,
    output logic [$clog2(TOKEN_MAX)-1:0] o_len
);

    localparam int LEN_W = $clog2(TOKEN_MAX);
    localparam logic [LEN_W-1:0] LIMIT = LEN_W'(TOKEN_MAX - 1);

    stu_pkg::t_mode     r_mode, n_mode;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_ovf, n_ovf;
    logic               accept;
    logic               is_word;
    logic               has_room;

    assign accept   = i_in_valid && !i_busy;
    assign is_word  = stu_pkg::is_word_byte(i_in_byte);
    assign has_room = r_len < LIMIT;

    assign o_waddr = r_len;
    assign o_wdata = i_in_byte;
    assign o_len   = r_len;

    always_comb begin
        n_mode = r_mode;
        n_len  = r_len;
        n_ovf  = r_ovf;
        o_we   = 1'b0;
        o_req  = '0;
        if (accept) begin
            unique case (r_mode)
                stu_pkg::MODE_IDLE: begin
                    n_len = '0;
                    n_ovf = 1'b0;
                    if (i_in_byte == stu_pkg::CH_NUL) begin
                        o_req.start    = 1'b1;
                        o_req.end_only = 1'b1;
                    end else if (!is_word) begin
                        n_mode = stu_pkg::MODE_IDLE;
                    end else if (i_in_byte == stu_pkg::CH_QUOTE) begin
                        n_mode = stu_pkg::MODE_QUOTED;
                    end else begin
                        o_we   = 1'b1;
                        n_len  = LEN_W'(1);
                        n_mode = (i_in_byte == stu_pkg::CH_SLASH) ? stu_pkg::MODE_SLASH
                                                                  : stu_pkg::MODE_WORD;
                    end
                end
                stu_pkg::MODE_COMMENT: begin
                    if (i_in_byte == stu_pkg::CH_NUL) begin
                        o_req.start    = 1'b1;
                        o_req.end_only = 1'b1;
                        n_mode         = stu_pkg::MODE_IDLE;
                        n_len          = '0;
                        n_ovf          = 1'b0;
                    end else if (i_in_byte == stu_pkg::CH_NL) begin
                        n_mode = stu_pkg::MODE_IDLE;
                    end
                end
                stu_pkg::MODE_QUOTED: begin
                    if (i_in_byte == stu_pkg::CH_QUOTE || i_in_byte == stu_pkg::CH_NUL) begin
                        o_req.start    = 1'b1;
                        o_req.empty    = r_ovf || (r_len == '0);
                        o_req.then_end = (i_in_byte == stu_pkg::CH_NUL);
                        n_mode         = stu_pkg::MODE_IDLE;
                        n_len          = '0;
                        n_ovf          = 1'b0;
                    end else if (has_room) begin
                        o_we  = 1'b1;
                        n_len = r_len + LEN_W'(1);
                    end
                end
                stu_pkg::MODE_SLASH, stu_pkg::MODE_WORD: begin
                    if ((r_mode == stu_pkg::MODE_SLASH) && (i_in_byte == stu_pkg::CH_SLASH)) begin
                        n_mode = stu_pkg::MODE_COMMENT;
                        n_len  = '0;
                        n_ovf  = 1'b0;
                    end else if (is_word) begin
                        n_mode = stu_pkg::MODE_WORD;
                        if (has_room) begin
                            o_we  = 1'b1;
                            n_len = r_len + LEN_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        o_req.start    = 1'b1;
                        o_req.empty    = r_ovf || (r_len == '0);
                        o_req.then_end = (i_in_byte == stu_pkg::CH_NUL);
                        n_mode         = stu_pkg::MODE_IDLE;
                        n_len          = '0;
                        n_ovf          = 1'b0;
                    end
                end
                default: begin
                    n_mode = stu_pkg::MODE_IDLE;
                    n_len  = '0;
                    n_ovf  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stu_pkg::MODE_IDLE;
            r_len  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
        end
    end

endmodule

// File: rtl/stu_emit.sv
module stu_emit #(
    parameter int TOKEN_MAX = stu_pkg::TOKEN_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stu_pkg::t_emit_req           i_req,
    input  logic [$clog2(TOKEN_MAX)-1:0] i_len,
    output logic                         o_busy,
    output logic                         o_re,
    output logic [$clog2(TOKEN_MAX)-1:0] o_raddr,
    input  logic [7:0]                   i_rdata,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_tok_char,
    output logic                         o_tok_last,
    output logic                         o_tok_empty,
    output logic                         o_data_end
);

    localparam int LEN_W = $clog2(TOKEN_MAX);

    stu_pkg::t_phase  r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_ptr, n_ptr;
    logic             r_then_end, n_then_end;
    logic             r_pend, n_pend;
    logic             r_pend_last, n_pend_last;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_char, n_char;
    logic             r_last, n_last;
    logic             r_empty, n_empty;
    logic             r_end, n_end;
    logic             can_load;

    assign can_load = !r_out_valid || !i_out_stall;
    assign o_busy   = (r_phase != stu_pkg::PH_IDLE);
    assign o_raddr  = r_ptr;

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_ptr       = r_ptr;
        n_then_end  = r_then_end;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = can_load ? 1'b0 : r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_empty     = r_empty;
        n_end       = r_end;
        o_re        = 1'b0;
        unique case (r_phase)
            stu_pkg::PH_IDLE: begin
                if (i_req.start) begin
                    n_len      = i_len;
                    n_ptr      = '0;
                    n_pend     = 1'b0;
                    n_then_end = i_req.then_end;
                    if (i_req.end_only) begin
                        n_phase = stu_pkg::PH_END;
                    end else if (i_req.empty) begin
                        n_phase = stu_pkg::PH_EMPTY;
                    end else begin
                        n_phase = stu_pkg::PH_CHARS;
                    end
                end
            end
            stu_pkg::PH_CHARS: begin
                // Drain the read that is in flight into the output register
                if (r_pend && can_load) begin
                    n_out_valid = 1'b1;
                    n_char      = i_rdata;
                    n_last      = r_pend_last;
                    n_empty     = 1'b0;
                    n_end       = 1'b0;
                    n_pend      = 1'b0;
                    if (r_pend_last) begin
                        n_phase = r_then_end ? stu_pkg::PH_END : stu_pkg::PH_IDLE;
                    end
                end
                // Issue the next read only when its data has a place to go
                if ((r_ptr != r_len) && (!r_pend || can_load)) begin
                    o_re        = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = ((r_ptr + LEN_W'(1)) == r_len);
                    n_ptr       = r_ptr + LEN_W'(1);
                end
            end
            stu_pkg::PH_EMPTY: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_char      = stu_pkg::CH_NUL;
                    n_last      = 1'b1;
                    n_empty     = 1'b1;
                    n_end       = 1'b0;
                    n_phase     = r_then_end ? stu_pkg::PH_END : stu_pkg::PH_IDLE;
                end
            end
            stu_pkg::PH_END: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_char      = stu_pkg::CH_NUL;
                    n_last      = 1'b1;
                    n_empty     = 1'b0;
                    n_end       = 1'b1;
                    n_phase     = stu_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = stu_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= stu_pkg::PH_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
            r_len       <= '0;
            r_then_end  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_ptr       <= n_ptr;
            r_len       <= n_len;
            r_then_end  <= n_then_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_char      <= n_char;
        r_last      <= n_last;
        r_empty     <= n_empty;
        r_end       <= n_end;
    end

    assign o_out_valid = r_out_valid;
    assign o_tok_char  = r_char;
    assign o_tok_last  = r_last;
    assign o_tok_empty = r_empty;
    assign o_data_end  = r_end;

endmodule

// File: rtl/script_tokenizer_unit.sv
// Streaming script tokenizer. Feed text one byte per input beat; a zero byte
// ends the data and yields an end-of-data beat (o_data_end) after any token in
// progress. Whitespace (bytes 1..32 and 128..255) and // line comments are
// skipped; a token is a quoted string (kept to TOKEN_MAX-1 characters) or a
// bare word (a word of TOKEN_MAX or more characters comes out as one empty
// beat). Each finished token comes out one character per output beat with
// o_tok_last on the final one, or as a single o_tok_empty beat. Timing: while
// scanning, one input byte is taken every cycle. The byte that ends a token
// starts an emit phase during which o_in_stall is high; the characters are
// read back from the token buffer through its single read port, one per cycle
// while i_out_stall is low, and any end marker is sent within the same phase. A
// finished beat may sit in the output register under i_out_stall while
// scanning of the next bytes goes on.
module script_tokenizer_unit #(
    parameter int TOKEN_MAX = stu_pkg::TOKEN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tok_char,
    output logic       o_tok_last,
    output logic       o_tok_empty,
    output logic       o_data_end
);

    localparam int ADDR_W = $clog2(TOKEN_MAX);

    stu_pkg::t_emit_req emit_req;
    logic               emit_busy;
    logic [ADDR_W-1:0]  tok_len;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [7:0]         mem_rdata;

    // Hold input while a finished token drains from the buffer; this also
    // keeps buffer writes and reads from ever touching the same token.
    assign o_in_stall = emit_busy;

    stu_scan #(
        .TOKEN_MAX (TOKEN_MAX)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_byte  (i_in_byte),
        .i_busy     (emit_busy),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_wdata    (mem_wdata),
        .o_req      (emit_req),
        .o_len      (tok_len)
    );

    // Token character buffer
    stu_ram #(
        .WIDTH (8),
        .DEPTH (TOKEN_MAX)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    stu_emit #(
        .TOKEN_MAX (TOKEN_MAX)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (emit_req),
        .i_len       (tok_len),
        .o_busy      (emit_busy),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tok_char  (o_tok_char),
        .o_tok_last  (o_tok_last),
        .o_tok_empty (o_tok_empty),
        .o_data_end  (o_data_end)
    );

endmodule

// File: rtl/stu_checker.sv
module stu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_in_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_tok_char,
    input logic       o_tok_last,
    input logic       o_tok_empty,
    input logic       o_data_end
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_tok_char) && $stable(o_tok_last)
            && $stable(o_tok_empty) && $stable(o_data_end))
        else $error("stalled output beat changed");

    // End marker is a lone last beat with no character
    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_data_end |-> o_tok_last && !o_tok_empty && (o_tok_char == 8'd0))
        else $error("malformed end marker");

    // Empty token is a lone last beat with no character
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tok_empty |-> o_tok_last && !o_data_end && (o_tok_char == 8'd0))
        else $error("malformed empty token");

    // Token characters are never zero
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tok_empty && !o_data_end |-> (o_tok_char != 8'd0))
        else $error("zero character inside token");

endmodule

bind script_tokenizer_unit stu_checker u_stu_checker (.*);
